// ===== hw/rtl/samd_pkg.sv =====
// Package for the six-axis admittance block: widths, reset values, register
// indexes, sequencer state type and lane control struct. No dependencies.
`timescale 1ns / 1ps
package samd_pkg;
    localparam int NUM_AXES      = 6;
    localparam int LIN_AXES      = 3;
    localparam int VALUE_W_DEF   = 32;
    localparam int REG_W         = 16;
    localparam int IDX_W         = 3;
    localparam int DEN_W         = 33;
    localparam int K_W           = 32;
    localparam logic [REG_W-1:0] MASS_LIN_RST = 16'd512;
    localparam logic [REG_W-1:0] MASS_ANG_RST = 16'd512;
    localparam logic [REG_W-1:0] DAMP_LIN_RST = 16'd2560;
    localparam logic [REG_W-1:0] DAMP_ANG_RST = 16'd5120;
    localparam logic [REG_W-1:0] RATE_RST     = 16'd500;

    typedef enum logic [IDX_W-1:0] {
        REG_MASS_LIN = 3'd0,
        REG_MASS_ANG = 3'd1,
        REG_DAMP_LIN = 3'd2,
        REG_DAMP_ANG = 3'd3,
        REG_RATE     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_lane_ctl;
endpackage

// ===== hw/rtl/samd_if.sv =====
// Valid/ready channel carrying six axis values.
// Depends on samd_pkg.
`timescale 1ns / 1ps
interface samd_if
    import samd_pkg::*;
#(parameter int VALUE_WIDTH = VALUE_W_DEF);
    logic valid;
    logic ready;
    logic signed [VALUE_WIDTH-1:0] f0, f1, f2, f3, f4, f5;
    modport source (output valid, f0, f1, f2, f3, f4, f5, input ready);
    modport sink   (input valid, f0, f1, f2, f3, f4, f5, output ready);
endinterface

// ===== hw/rtl/samd_lane.sv =====
// One axis lane: sign-magnitude numerator build, then restoring division
// one quotient bit per cycle, then saturation. Depends on samd_pkg.
`timescale 1ns / 1ps
module samd_lane
    import samd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic [VALUE_WIDTH-1:0]        i_force,
    input  logic [VALUE_WIDTH-1:0]        i_prev,
    input  logic [K_W-1:0]                i_k,
    input  logic [DEN_W-1:0]              i_den,
    output logic [VALUE_WIDTH-1:0]        o_vel
);
    localparam int NUM_W = VALUE_WIDTH + K_W + 1;
    localparam int Q_W   = NUM_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]       r_num, n_num;
    logic                   r_neg, n_neg;
    logic                   r_zero, n_zero;
    logic [DEN_W:0]         r_rem, n_rem;
    logic [Q_W-1:0]         r_q, n_q;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_vel, n_vel;

    logic                   f_neg, v_neg, neg_sel;
    logic [VALUE_WIDTH-1:0] f_mag, v_mag;
    logic [VALUE_WIDTH+K_W-1:0] prod;
    logic [NUM_W-1:0]       a_w, b_w, num_w;
    logic [DEN_W:0]         rem_sh;
    logic [VALUE_WIDTH-1:0] lim;

    always_comb begin
        f_neg = i_force[VALUE_WIDTH-1];
        v_neg = i_prev[VALUE_WIDTH-1];
        f_mag = f_neg ? (~i_force + 1'b1) : i_force;
        v_mag = v_neg ? (~i_prev + 1'b1) : i_prev;
        a_w = NUM_W'({f_mag, 8'd0});
        prod = v_mag * i_k;
        b_w = NUM_W'(prod);
        if (f_neg == v_neg) begin
            num_w = a_w + b_w;
            neg_sel = f_neg;
        end else if (a_w >= b_w) begin
            num_w = a_w - b_w;
            neg_sel = f_neg;
        end else begin
            num_w = b_w - a_w;
            neg_sel = v_neg;
        end
    end

    always_comb begin
        n_num  = r_num;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_vel  = r_vel;
        rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        lim = r_neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        if (i_ctl.start) begin
            n_num  = num_w;
            n_neg  = neg_sel;
            n_zero = (num_w == '0);
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = CNT_W'(NUM_W);
        end else if (i_ctl.busy && r_cnt != '0) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (rem_sh >= {1'b0, i_den}) begin
                n_rem = rem_sh - {1'b0, i_den};
                n_q   = {r_q[Q_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[Q_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(1)) begin
                if (r_zero) begin
                    n_vel = '0;
                end else if (i_den == '0) begin
                    n_vel = lim;
                end else if (n_q > Q_W'(lim) || (n_q == Q_W'(lim) && !r_neg)) begin
                    n_vel = (n_q == Q_W'(lim) && !r_neg) ? lim : lim;
                end else begin
                    n_vel = r_neg ? (~n_q[VALUE_WIDTH-1:0] + 1'b1) : n_q[VALUE_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_vel <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_vel <= n_vel;
        end
        r_num  <= n_num;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_rem  <= n_rem;
        r_q    <= n_q;
    end

    assign o_vel = r_vel;
endmodule

// ===== hw/rtl/samd_ctrl.sv =====
// Configuration registers, shared mass*rate products and item sequencer.
// Depends on samd_pkg.
`timescale 1ns / 1ps
module samd_ctrl
    import samd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_in_fire,
    input  logic             i_out_fire,
    output t_lane_ctl        o_ctl,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [K_W-1:0]   o_k_lin,
    output logic [K_W-1:0]   o_k_ang,
    output logic [DEN_W-1:0] o_den_lin,
    output logic [DEN_W-1:0] o_den_ang
);
    localparam int NUM_W = VALUE_WIDTH + K_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 2);

    logic [REG_W-1:0] r_ml, r_ma, r_dl, r_da, r_rate;
    logic [K_W-1:0]   r_kl, r_ka;
    t_state           r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml <= MASS_LIN_RST;
            r_ma <= MASS_ANG_RST;
            r_dl <= DAMP_LIN_RST;
            r_da <= DAMP_ANG_RST;
            r_rate <= RATE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MASS_LIN: r_ml <= i_cfg_data;
                REG_MASS_ANG: r_ma <= i_cfg_data;
                REG_DAMP_LIN: r_dl <= i_cfg_data;
                REG_DAMP_ANG: r_da <= i_cfg_data;
                REG_RATE:     r_rate <= i_cfg_data;
                default: ;
            endcase
        end
        r_kl <= r_ml * r_rate;
        r_ka <= r_ma * r_rate;
    end

    assign o_k_lin   = r_kl;
    assign o_k_ang   = r_ka;
    assign o_den_lin = DEN_W'(r_kl) + DEN_W'(r_dl);
    assign o_den_ang = DEN_W'(r_ka) + DEN_W'(r_da);

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        o_ctl = '0;
        case (r_st)
            ST_IDLE: if (i_in_fire) begin
                n_st = ST_MUL;
            end
            ST_MUL: begin
                o_ctl.start = 1'b1;
                n_cnt = CNT_W'(NUM_W);
                n_st  = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.busy = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) n_st = ST_OUT;
            end
            ST_OUT: if (i_out_fire) begin
                n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end

    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_out_valid = (r_st == ST_OUT);
endmodule

// ===== hw/rtl/six_axis_admittance_mass_damper.sv =====
// Six-axis admittance filter, backward-Euler mass-damper per axis. After a
// wrench is accepted, each lane builds its numerator from the registered
// mass*rate products, then runs VALUE_WIDTH+33 restoring divider steps in
// each of six lanes, then the result waits in the output register.
// The next wrench is accepted in the cycle after the twist leaves, so a new item is never taken
// before the last one is through. Depends on samd_pkg, samd_if, samd_ctrl, samd_lane.
`timescale 1ns / 1ps
module six_axis_admittance_mass_damper
    import samd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    samd_if.sink             s_in,
    samd_if.source           m_out
);
    t_lane_ctl ctl;
    logic in_ready, out_valid;
    logic [K_W-1:0] k_lin, k_ang;
    logic [DEN_W-1:0] den_lin, den_ang;
    logic [VALUE_WIDTH-1:0] r_f [NUM_AXES];
    logic [VALUE_WIDTH-1:0] vel [NUM_AXES];

    assign s_in.ready  = in_ready;
    assign m_out.valid = out_valid;

    samd_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_fire(s_in.valid && in_ready),
        .i_out_fire(out_valid && m_out.ready),
        .o_ctl(ctl), .o_in_ready(in_ready), .o_out_valid(out_valid),
        .o_k_lin(k_lin), .o_k_ang(k_ang), .o_den_lin(den_lin), .o_den_ang(den_ang)
    );

    always_ff @(posedge i_clk) begin
        if (s_in.valid && in_ready) begin
            r_f[0] <= s_in.f0; r_f[1] <= s_in.f1; r_f[2] <= s_in.f2;
            r_f[3] <= s_in.f3; r_f[4] <= s_in.f4; r_f[5] <= s_in.f5;
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        samd_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane (
            .i_clk, .i_rst_n, .i_ctl(ctl),
            .i_force(r_f[g]), .i_prev(vel[g]),
            .i_k(g < LIN_AXES ? k_lin : k_ang),
            .i_den(g < LIN_AXES ? den_lin : den_ang),
            .o_vel(vel[g])
        );
    end

    assign m_out.f0 = vel[0];
    assign m_out.f1 = vel[1];
    assign m_out.f2 = vel[2];
    assign m_out.f3 = vel[3];
    assign m_out.f4 = vel[4];
    assign m_out.f5 = vel[5];
endmodule

// ===== hw/rtl/samd_checker.sv =====
// Port-level checks for the admittance block, bound to the top level.
// Depends on six_axis_admittance_mass_damper.
`timescale 1ns / 1ps
module samd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("accept while result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("ready after accept");
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 !i_out_valid) else $error("result too early");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
endmodule

bind six_axis_admittance_mass_damper samd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready)
);

// ===== dv/tb_six_axis_admittance_mass_damper.sv =====
// Testbench for the six-axis admittance filter: a directed table of wrench items and
// register writes, then random phases, checked against an own per-axis predictor.
// Depends on samd_pkg, samd_if and six_axis_admittance_mass_damper.
`timescale 1ns / 1ps
module tb_six_axis_admittance_mass_damper;
    import samd_pkg::*;

    localparam int VW          = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 100;
    localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd5;
    localparam logic [IDX_W-1:0] IDX_TOP    = 3'd7;

    typedef logic [NUM_AXES-1:0][VW-1:0] t_axes;

    typedef struct {
        bit               is_cfg;
        logic [IDX_W-1:0] idx;
        logic [REG_W-1:0] data;
        t_axes            wrench;
        bit               known;
        t_axes            twist;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [REG_W-1:0] cfg_data = '0;

    samd_if #(.VALUE_WIDTH(VW)) in_ch ();
    samd_if #(.VALUE_WIDTH(VW)) out_ch ();

    six_axis_admittance_mass_damper #(.VALUE_WIDTH(VW)) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .s_in      (in_ch),
        .m_out     (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [REG_W-1:0] mass_lin, mass_ang, damp_lin, damp_ang, upd_rate;
    logic [VW-1:0]    vel_prev [NUM_AXES];
    t_axes            twist_q [$];
    t_row             rows [$];
    int               errors = 0;
    int               n_items = 0;
    int               n_twists = 0;
    int               n_writes = 0;
    int               cycles = 0;
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.f0 = '0; in_ch.f1 = '0; in_ch.f2 = '0;
        in_ch.f3 = '0; in_ch.f4 = '0; in_ch.f5 = '0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [VW-1:0] axis_velocity(logic [VW-1:0] f, logic [VW-1:0] p,
                                                    logic [REG_W-1:0] m, logic [REG_W-1:0] d);
        logic [31:0]        k;
        logic signed [127:0] fs, ps, ks, n;
        logic [127:0]       mag, den, q, lim;
        logic               neg;
        k   = 32'(m) * 32'(upd_rate);
        fs  = $signed({{(128-VW){f[VW-1]}}, f});
        ps  = $signed({{(128-VW){p[VW-1]}}, p});
        ks  = $signed({96'd0, k});
        n   = fs * 256 + ps * ks;
        neg = n < 0;
        mag = neg ? -n : n;
        if (mag == 0) return '0;
        den = 128'(k) + 128'(d);
        q   = (den == 0) ? {128{1'b1}} : mag / den;
        lim = neg ? (128'd1 << (VW-1)) : ((128'd1 << (VW-1)) - 1);
        if (q > lim) q = lim;
        return neg ? VW'(-q) : VW'(q);
    endfunction

    function automatic t_axes twist_next(t_axes w);
        t_axes v;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i < LIN_AXES) v[i] = axis_velocity(w[i], vel_prev[i], mass_lin, damp_lin);
            else              v[i] = axis_velocity(w[i], vel_prev[i], mass_ang, damp_ang);
            vel_prev[i] = v[i];
        end
        return v;
    endfunction

    function automatic void add_item(t_axes w, bit known = 1'b0, t_axes t = '0);
        t_row r;
        r.is_cfg = 1'b0; r.idx = '0; r.data = '0;
        r.wrench = w; r.known = known; r.twist = t;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        t_row r;
        r.is_cfg = 1'b1; r.idx = idx; r.data = data;
        r.wrench = '0; r.known = 1'b0; r.twist = '0;
        rows.push_back(r);
    endfunction

    function automatic logic [VW-1:0] rand_value();
        case ($urandom_range(0, 3))
            0, 1:    return VW'($urandom);
            2:       return VW'($signed($urandom_range(0, 131072)) - 65536);
            default: return VW'($signed($urandom_range(0, 33554432)) - 16777216);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_reg(logic [REG_W-1:0] lo);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return 16'hFFFF;
            default: return REG_W'($urandom_range(lo, 16'hFFFF));
        endcase
    endfunction

    task automatic wait_idle();
        while (twist_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        wait_idle();
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MASS_LIN: mass_lin = data;
            REG_MASS_ANG: mass_ang = data;
            REG_DAMP_LIN: damp_lin = data;
            REG_DAMP_ANG: damp_ang = data;
            REG_RATE:     upd_rate = data;
            default: ;
        endcase
        n_writes++;
    endtask

    // valid is already high or low from the previous step; it may be dropped for a random gap before it is raised
    task automatic send_wrench(t_axes w, bit known, t_axes t);
        t_axes exp_v;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.f0 <= w[0]; in_ch.f1 <= w[1]; in_ch.f2 <= w[2];
        in_ch.f3 <= w[3]; in_ch.f4 <= w[4]; in_ch.f5 <= w[5];
        do @(posedge i_clk); while (!in_ch.ready);
        exp_v = twist_next(w);
        twist_q.push_back(known ? t : exp_v);
        n_items++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: check accepted twists, drive ready
    initial begin
        t_axes got, want;
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.f5, out_ch.f4, out_ch.f3, out_ch.f2, out_ch.f1, out_ch.f0};
                if (twist_q.size() == 0) begin
                    $display("%0t: unexpected twist %h", $time, got);
                    errors++;
                end else begin
                    want = twist_q.pop_front();
                    for (int i = 0; i < NUM_AXES; i++)
                        if (got[i] !== want[i]) begin
                            $display("%0t: axis %0d expected %h actual %h",
                                     $time, i, want[i], got[i]);
                            errors++;
                        end
                    n_twists++;
                end
            end
            if (hold_req && hold == 0) hold = HOLD_CYCLES;
            if (hold > 0) begin
                hold--;
                if (hold == 0) hold_req = 1'b0;
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_axes w;
        localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
        localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
        mass_lin = MASS_LIN_RST; mass_ang = MASS_ANG_RST;
        damp_lin = DAMP_LIN_RST; damp_ang = DAMP_ANG_RST;
        upd_rate = RATE_RST;
        for (int i = 0; i < NUM_AXES; i++) vel_prev[i] = '0;

        // after reset, zero wrench gives zero twist
        add_item('0, 1'b1, '0);
        add_item({NUM_AXES{VMAX}});
        add_item({NUM_AXES{VMIN}});
        add_item({VMIN, VMAX, VW'(-1), VW'(1), VMIN, VMAX});
        add_item({NUM_AXES{VW'(32'h0001_0000)}});
        add_item('0);
        // unity divisor: a full-scale positive push saturates high
        add_cfg(REG_MASS_LIN, 16'd1); add_cfg(REG_MASS_ANG, 16'd1);
        add_cfg(REG_DAMP_LIN, 16'd0); add_cfg(REG_DAMP_ANG, 16'd0);
        add_cfg(REG_RATE, 16'd1);
        add_item('0);
        add_item({NUM_AXES{VMAX}}, 1'b1, {NUM_AXES{VMAX}});
        add_item({NUM_AXES{VMIN}});
        add_item({NUM_AXES{VMIN}});
        add_item({VMAX, VMIN, VMAX, VMIN, VMAX, VMIN});
        // largest mass, rate and damping
        add_cfg(REG_MASS_LIN, 16'hFFFF); add_cfg(REG_MASS_ANG, 16'hFFFF);
        add_cfg(REG_DAMP_LIN, 16'hFFFF); add_cfg(REG_DAMP_ANG, 16'hFFFF);
        add_cfg(REG_RATE, 16'hFFFF);
        add_item({NUM_AXES{VMAX}});
        add_item({NUM_AXES{VMIN}});
        // unused index leaves every register as is
        add_cfg(IDX_UNUSED, 16'h0001);
        add_cfg(IDX_TOP, 16'h0000);
        add_item({VW'(-5), VW'(5), VMAX, VMIN, VW'(12345), VW'(-99999)});
        add_cfg(REG_MASS_LIN, 16'd300); add_cfg(REG_DAMP_ANG, 16'd0);
        add_item({VMAX, VMAX, VMIN, VMIN, VW'(0), VW'(7)});
        add_item({VMAX, VMAX, VMIN, VMIN, VW'(0), VW'(7)});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                in_ch.valid <= 1'b0;
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                send_wrench(rows[r].wrench, rows[r].known, rows[r].twist);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            write_reg(REG_MASS_LIN, rand_reg(16'd1));
            write_reg(REG_MASS_ANG, rand_reg(16'd1));
            write_reg(REG_DAMP_LIN, rand_reg(16'd0));
            write_reg(REG_DAMP_ANG, rand_reg(16'd0));
            write_reg(REG_RATE, rand_reg(16'd1));
            if (ph == RAND_PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 10) hold_req = 1'b1;
                for (int i = 0; i < NUM_AXES; i++) w[i] = rand_value();
                send_wrench(w, 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        while (twist_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Ran %0d wrench items and %0d register writes, %0d twists checked.",
                 n_items, n_writes, n_twists);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
